FILE: rtl/bpfa_pkg.sv
`default_nettype none
package bpfa_pkg;

    typedef enum logic [1:0] {
        MODE_ALLOC   = 2'd0,
        MODE_FREE    = 2'd1,
        MODE_RESERVE = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_NO_RUN  = 2'd1;
    localparam logic [1:0] STATUS_ZERO    = 2'd2;

    localparam int COUNT_W = 17;
    localparam int ADDR_W  = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_start;   // Begin the reset clearing pass.
        logic clear_step;    // Write one all-ones word and advance.
        logic load;          // Capture a new transaction.
        logic rd;            // Issue a read at the current word.
        logic scan;          // Consume read data during an allocate scan.
        logic upd;           // Consume read data during a range update.
        logic mark_init;     // Rewind to the start of the found run for marking.
        logic fin_alloc;     // Write the allocate result.
        logic fin_fail;      // Write a no-run result.
        logic fin_range;     // Write a free or reserve result.
        logic fin_none;      // Write a zero or unused-mode result.
    } bpfa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic found;
        logic scan_end;
        logic range_end;
        logic zero_count;
        logic [1:0] mode;
    } bpfa_sts_t;

endpackage
`default_nettype wire

FILE: rtl/bitmap_page_frame_allocator.sv
`default_nettype none
// First-fit bitmap page frame allocator.
// A transaction is accepted at a rising edge where start is high and busy is
// low; mode, phys_address and page_count are sampled then. Mode 0 allocates a
// run of page_count free pages, mode 1 frees a range and mode 2 reserves one.
// Exactly one result follows per transaction, shown for one cycle with done
// high; the receiver cannot stall, so results are never held.
// An allocate scan reads and then checks one step at a time, stepping a
// whole word when the scan is at the first page of a fully used word and
// one page otherwise, then marks the found run one page at a time. Free and
// reserve read and update one page of the range at a time. A zero-count or
// unused-mode request goes from dispatch straight to its result, and each
// transaction passes through an output state with busy high before the next
// one can be taken. The worst case is a full-store scan and mark or a range
// of 131071 pages.
// After reset a clearing pass writes every bitmap word to all ones with busy
// high; the managed page limit may be written at any time the block is idle
// through cfg_we and cfg_data.
module bitmap_page_frame_allocator #(
    parameter int MAX_PAGES  = 65536,
    parameter int WORD_BITS  = 32,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    output logic              done,
    input  wire logic [1:0]   mode,
    input  wire logic [31:0]  phys_address,
    input  wire logic [16:0]  page_count,
    input  wire logic         cfg_we,
    input  wire logic [16:0]  cfg_data,
    output logic [31:0]       result_address,
    output logic [1:0]        status,
    output logic              was_unaligned,
    output logic              skipped_out_of_range,
    output logic              skipped_already_set,
    output logic [16:0]       used_pages
);
    bpfa_pkg::bpfa_cmd_t cmd;
    bpfa_pkg::bpfa_sts_t sts;
    logic [31:0] page_addr;

    bpfa_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cmd(cmd), .sts(sts)
    );

    bpfa_datapath #(
        .MAX_PAGES(MAX_PAGES), .WORD_BITS(WORD_BITS), .PAGE_SHIFT(PAGE_SHIFT)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .mode(mode), .phys_address(phys_address), .page_count(page_count),
        .cfg_we(cfg_we), .cfg_data(cfg_data),
        .result_address(page_addr), .status(status),
        .was_unaligned(was_unaligned),
        .skipped_out_of_range(skipped_out_of_range),
        .skipped_already_set(skipped_already_set),
        .used_pages(used_pages)
    );

    // The datapath reports the page number; scale it to a byte address.
    assign result_address = page_addr << PAGE_SHIFT;

endmodule
`default_nettype wire

FILE: rtl/bpfa_datapath.sv
`default_nettype none
module bpfa_datapath #(
    parameter int MAX_PAGES  = 65536,
    parameter int WORD_BITS  = 32,
    parameter int PAGE_SHIFT = 12
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire bpfa_pkg::bpfa_cmd_t             cmd,
    output bpfa_pkg::bpfa_sts_t                  sts,
    input  wire logic [1:0]                      mode,
    input  wire logic [bpfa_pkg::ADDR_W-1:0]     phys_address,
    input  wire logic [bpfa_pkg::COUNT_W-1:0]    page_count,
    input  wire logic                            cfg_we,
    input  wire logic [bpfa_pkg::COUNT_W-1:0]    cfg_data,
    output logic [bpfa_pkg::ADDR_W-1:0]          result_address,
    output logic [1:0]                           status,
    output logic                                 was_unaligned,
    output logic                                 skipped_out_of_range,
    output logic                                 skipped_already_set,
    output logic [bpfa_pkg::COUNT_W-1:0]         used_pages
);
    localparam int WORDS = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W  = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BI_W  = $clog2(WORD_BITS);
    localparam int AD_W  = bpfa_pkg::ADDR_W;
    // A range may start at any page of the address space and run past it by
    // a full count, so the page counter covers both.
    localparam int PG_A  = AD_W - PAGE_SHIFT + 1;
    localparam int PG_M  = $clog2(MAX_PAGES + 1) + 1;
    localparam int PG_W  = (PG_A > PG_M) ? PG_A : PG_M;
    localparam int UC_W  = $clog2(MAX_PAGES + 1);
    localparam int CC_W  = bpfa_pkg::COUNT_W;

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORD_BITS-1:0] rdata;

    logic [WA_W:0]      clr_reg;
    logic [PG_W-1:0]    limit_reg;
    logic [1:0]         mode_reg;
    logic [PG_W-1:0]    page_reg;     // current page for scan/update
    logic [CC_W-1:0]    count_reg;
    logic [CC_W-1:0]    left_reg;     // remaining pages of range
    logic [CC_W-1:0]    run_reg;
    logic [PG_W-1:0]    start_reg;
    logic               found_reg;
    logic               unal_reg;
    logic               oor_reg;
    logic               alr_reg;
    logic [UC_W-1:0]    used_reg;
    logic               marking_reg;

    // Managed limit, clamped to the store size.
    logic [PG_W-1:0] cfg_ext;
    assign cfg_ext = PG_W'(cfg_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= PG_W'(MAX_PAGES < 65536 ? MAX_PAGES : 65536);
        else if (cfg_we)
            limit_reg <= (cfg_ext > PG_W'(MAX_PAGES)) ? PG_W'(MAX_PAGES) : cfg_ext;
    end

    logic [WA_W-1:0] waddr;
    logic [BI_W-1:0] bidx;
    assign waddr = WA_W'(page_reg >> BI_W);
    assign bidx  = page_reg[BI_W-1:0];

    // Bit-serial per word for clarity of flags: one page per read-and-check step
    // within a word, but the scan skips a fully used word in one step from its first page.
    logic            in_range;
    logic            bit_used;
    logic            word_full;
    assign in_range  = page_reg < limit_reg;
    assign bit_used  = rdata[bidx];
    assign word_full = (rdata == {WORD_BITS{1'b1}}) && (bidx == '0);

    logic [WORD_BITS-1:0] wmask;
    assign wmask = WORD_BITS'(1) << bidx;

    logic            we;
    logic [WORD_BITS-1:0] wdata;
    logic [WA_W-1:0] wa;
    always_comb
    begin
        we    = 1'b0;
        wdata = rdata;
        wa    = waddr;
        if (cmd.clear_step)
        begin
            we    = 1'b1;
            wdata = '1;
            wa    = clr_reg[WA_W-1:0];
        end
        else if (cmd.upd && in_range && (left_reg != '0))
        begin
            if (mode_reg == bpfa_pkg::MODE_FREE && bit_used)
            begin
                we = 1'b1; wdata = rdata & ~wmask;
            end
            else if (mode_reg != bpfa_pkg::MODE_FREE && !bit_used)
            begin
                we = 1'b1; wdata = rdata | wmask;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wdata;
        if (cmd.rd)
            rdata <= (we && wa == waddr) ? wdata : mem[waddr];
    end

    logic [CC_W-1:0] run_inc;
    assign run_inc = run_reg + CC_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg     <= '0;
            used_reg    <= UC_W'(MAX_PAGES);
            mode_reg    <= '0;
            page_reg    <= '0;
            count_reg   <= '0;
            left_reg    <= '0;
            run_reg     <= '0;
            start_reg   <= '0;
            found_reg   <= 1'b0;
            unal_reg    <= 1'b0;
            oor_reg     <= 1'b0;
            alr_reg     <= 1'b0;
            marking_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_start)
                clr_reg <= '0;
            if (cmd.clear_step)
                clr_reg <= clr_reg + (WA_W+1)'(1);
            if (cmd.load)
            begin
                mode_reg    <= mode;
                count_reg   <= page_count;
                run_reg     <= '0;
                found_reg   <= 1'b0;
                oor_reg     <= 1'b0;
                alr_reg     <= 1'b0;
                marking_reg <= 1'b0;
                unal_reg    <= (mode == bpfa_pkg::MODE_FREE || mode == bpfa_pkg::MODE_RESERVE)
                               && (phys_address[PAGE_SHIFT-1:0] != '0);
                if (mode == bpfa_pkg::MODE_ALLOC)
                    page_reg <= '0;
                else
                    page_reg <= PG_W'(phys_address >> PAGE_SHIFT);
                left_reg <= page_count;
            end
            if (cmd.scan)
            begin
                if (word_full && in_range)
                begin
                    run_reg  <= '0;
                    page_reg <= page_reg + PG_W'(WORD_BITS);
                end
                else if (in_range)
                begin
                    if (bit_used)
                        run_reg <= '0;
                    else
                    begin
                        if (run_reg == '0)
                            start_reg <= page_reg;
                        run_reg <= run_inc;
                        if (run_inc == count_reg)
                            found_reg <= 1'b1;
                    end
                    page_reg <= page_reg + PG_W'(1);
                end
            end
            if (cmd.mark_init)
            begin
                page_reg    <= start_reg;
                left_reg    <= count_reg;
                marking_reg <= 1'b1;
                mode_reg    <= bpfa_pkg::MODE_RESERVE;
            end
            if (cmd.upd)
            begin
                if (left_reg != '0)
                begin
                    if (!in_range)
                        oor_reg <= 1'b1;
                    else if (bit_used == (mode_reg != bpfa_pkg::MODE_FREE))
                        alr_reg <= 1'b1;
                    else if (mode_reg == bpfa_pkg::MODE_FREE)
                        used_reg <= used_reg - UC_W'(1);
                    else
                        used_reg <= used_reg + UC_W'(1);
                    page_reg <= page_reg + PG_W'(1);
                    left_reg <= left_reg - CC_W'(1);
                end
            end
        end
    end

    // Result register: the strobe is driven by the controller.
    always_ff @(posedge clk)
    begin
        if (cmd.fin_alloc)
        begin
            result_address       <= AD_W'(start_reg);
            status               <= bpfa_pkg::STATUS_OK;
            was_unaligned        <= 1'b0;
            skipped_out_of_range <= 1'b0;
            skipped_already_set  <= 1'b0;
            used_pages           <= CC_W'(used_reg);
        end
        else if (cmd.fin_fail || cmd.fin_range || cmd.fin_none)
        begin
            result_address       <= '0;
            status               <= cmd.fin_fail ? bpfa_pkg::STATUS_NO_RUN :
                                    ((count_reg == '0 && mode_reg != bpfa_pkg::MODE_NONE)
                                     ? bpfa_pkg::STATUS_ZERO : bpfa_pkg::STATUS_OK);
            was_unaligned        <= unal_reg;
            skipped_out_of_range <= oor_reg;
            skipped_already_set  <= alr_reg;
            used_pages           <= CC_W'(used_reg);
        end
    end

    assign sts.clear_done = (clr_reg == (WA_W+1)'(WORDS));
    assign sts.found      = found_reg;
    assign sts.scan_end   = !in_range;
    assign sts.range_end  = (left_reg == '0);
    assign sts.zero_count = (count_reg == '0);
    assign sts.mode       = marking_reg ? bpfa_pkg::MODE_ALLOC : mode_reg;

endmodule
`default_nettype wire

FILE: rtl/bpfa_ctrl.sv
`default_nettype none
module bpfa_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    output logic                       done,
    output bpfa_pkg::bpfa_cmd_t        cmd,
    input  wire bpfa_pkg::bpfa_sts_t   sts
);
    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DISPATCH, S_SRD, S_SCAN, S_MARKINIT,
        S_URD, S_UPD, S_FIN_A, S_FIN_F, S_FIN_R, S_FIN_N, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (sts.clear_done)
                    state_next = S_IDLE;
                else
                    cmd.clear_step = 1'b1;
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (sts.mode == bpfa_pkg::MODE_NONE || sts.zero_count)
                    state_next = S_FIN_N;
                else if (sts.mode == bpfa_pkg::MODE_ALLOC)
                    state_next = S_SRD;
                else
                    state_next = S_URD;
            end
            S_SRD:
            begin
                if (sts.found)
                    state_next = S_MARKINIT;
                else if (sts.scan_end)
                    state_next = S_FIN_F;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan   = 1'b1;
                state_next = S_SRD;
            end
            S_MARKINIT:
            begin
                cmd.mark_init = 1'b1;
                state_next    = S_URD;
            end
            S_URD:
            begin
                if (sts.range_end)
                    state_next = (sts.mode == bpfa_pkg::MODE_ALLOC) ? S_FIN_A : S_FIN_R;
                else
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_URD;
            end
            S_FIN_A: begin cmd.fin_alloc = 1'b1; state_next = S_OUT; end
            S_FIN_F: begin cmd.fin_fail  = 1'b1; state_next = S_OUT; end
            S_FIN_R: begin cmd.fin_range = 1'b1; state_next = S_OUT; end
            S_FIN_N: begin cmd.fin_none  = 1'b1; state_next = S_OUT; end
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.fin_alloc | cmd.fin_fail | cmd.fin_range | cmd.fin_none;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;

endmodule
`default_nettype wire
